// File: hdl/parsimony_fitness_scaler_defines.svh
// Assertion macros for the parsimony fitness scaler.
// Included by files that carry concurrent checks; needs clk and rst in scope.
`ifndef PARSIMONY_FITNESS_SCALER_DEFINES_SVH
`define PARSIMONY_FITNESS_SCALER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("pfs check failed");
`define PFS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("pfs check failed");
`else
`define PFS_ASSERT(lbl, prop)
`define PFS_NEVER(lbl, cond)
`endif
`endif

// File: hdl/pfs_pkg.sv
// Shared types and constants for the parsimony fitness scaler.
// No dependencies.
package pfs_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int POP        = 64;
  localparam int SLOT_W     = 6;
  localparam int CNT_W      = 7;
  localparam int LOSS_W     = 32;
  localparam int NODE_W     = 10;
  localparam int FIT_W      = 48;
  localparam int SF_W       = 54;
  localparam int SN_W       = 16;
  localparam int SFN_W      = 64;
  localparam int SNN_W      = 26;
  localparam int DIV_W      = 71;
  localparam int DSR_W      = 32;
  localparam int ITER_W     = 7;
  localparam int RECIP_W    = 2 * FRAC_BITS + 1;
  localparam int CT_W       = 49;
  localparam int PROD_W     = CT_W + NODE_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int MEM_W      = FIT_W + NODE_W;

  localparam logic [FIT_W-1:0] FIT_MAX = {1'b0, {(FIT_W-1){1'b1}}};
  localparam logic [CT_W-1:0]  CT_CLAMP = {1'b1, {(CT_W-1){1'b0}}};

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
    logic [ITER_W-1:0] iters;
  } pfs_div_req_t;
endpackage

// File: hdl/parsimony_fitness_scaler.sv
// Parsimony fitness scaler: each request (loss, NaN flag, node count) is
// scored by the 33-step reciprocal in the shared serial divider; NaN and zero
// losses skip it. The request marked last closes the population: a 71-step
// divide finds the coefficient (if parsimony is enabled, denominator nonzero),
// then each fitness is emitted in load order, held while out_ready is low.
module parsimony_fitness_scaler import pfs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [LOSS_W-1:0]       loss,
  input  logic                    loss_is_nan,
  input  logic [NODE_W-1:0]       node_count,
  input  logic                    last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [FIT_W-1:0] fitness,
  output logic [SLOT_W-1:0]       slot,
  output logic                    last_out,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    parsimony_enable
);
`include "parsimony_fitness_scaler_defines.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVW  = 4'd1;
  localparam logic [3:0] S_STORE = 4'd2;
  localparam logic [3:0] S_CT1   = 4'd3;
  localparam logic [3:0] S_CT2   = 4'd4;
  localparam logic [3:0] S_CTW   = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(signed'({1'b0, FIT_MAX}));
  localparam logic signed [ACC_W-1:0] ACC_MIN = ~ACC_MAX;

  logic [3:0]        state;
  logic              enable_reg;
  logic              cur_last;
  logic [NODE_W-1:0] cur_nodes;
  logic [FIT_W-1:0]  cur_fit;
  logic [CNT_W-1:0]  item_count;
  logic [SF_W-1:0]   sum_fitness;
  logic [SN_W-1:0]   sum_nodes;
  logic [SFN_W-1:0]  sum_fit_nodes;
  logic [SNN_W-1:0]  sum_nodes_sq;
  logic [DIV_W-1:0]  term_a;
  logic [DIV_W-1:0]  term_b;
  logic [DSR_W-1:0]  term_c;
  logic [DSR_W-1:0]  term_d;
  logic [CT_W-1:0]   ct;
  logic              ct_neg;
  logic [CNT_W-1:0]  k;
  logic [FIT_W-1:0]  emit_fit;
  logic [PROD_W-1:0] emit_prod;

  pfs_div_req_t      div_req;
  logic              div_busy;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;

  logic              mem_we;
  logic              mem_re;
  logic [MEM_W-1:0]  mem_rdata;

  logic [DIV_W-1:0]  mag;
  logic              mag_neg;
  logic [DSR_W-1:0]  den;
  logic signed [ACC_W-1:0] fx;
  logic signed [ACC_W-1:0] px;
  logic signed [ACC_W-1:0] acc;
  logic [FIT_W-1:0]  sat_fit;
  logic              out_load;
  logic              in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign mem_we    = (state == S_STORE);
  assign mem_re    = (state == S_RD);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  assign mag_neg = term_b > term_a;
  assign mag     = mag_neg ? term_b - term_a : term_a - term_b;
  assign den     = (term_c >= term_d) ? term_c - term_d : '0;

  assign fx  = signed'(ACC_W'(emit_fit));
  assign px  = signed'(ACC_W'(emit_prod));
  assign acc = ct_neg ? fx + px : fx - px;

  always_comb begin
    priority if (acc > ACC_MAX) begin
      sat_fit = FIT_MAX;
    end else if (acc < ACC_MIN) begin
      sat_fit = ~FIT_MAX;
    end else begin
      sat_fit = acc[FIT_W-1:0];
    end
  end

  always_comb begin
    div_req          = '0;
    div_req.dividend = {{1'b1, {(RECIP_W-1){1'b0}}}, {(DIV_W-RECIP_W){1'b0}}};
    div_req.divisor  = loss;
    div_req.iters    = ITER_W'(RECIP_W);
    if (in_acc && (item_count < CNT_W'(POP)) && !loss_is_nan && (loss != '0)) begin
      div_req.start = 1'b1;
    end else if (state == S_CT2 && enable_reg && den != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = mag;
      div_req.divisor  = den;
      div_req.iters    = ITER_W'(DIV_W);
    end
  end

  pfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  pfs_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (item_count[SLOT_W-1:0]),
    .wdata ({cur_fit, cur_nodes}),
    .re    (mem_re),
    .raddr (k[SLOT_W-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_reg <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable_reg <= parsimony_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      item_count    <= '0;
      sum_fitness   <= '0;
      sum_nodes     <= '0;
      sum_fit_nodes <= '0;
      sum_nodes_sq  <= '0;
      out_valid     <= 1'b0;
      k             <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cur_last  <= last;
            cur_nodes <= node_count;
            if (item_count >= CNT_W'(POP)) begin
              // population full: drop the request, honor last
              if (last) begin
                state <= S_CT1;
              end
            end else if (loss_is_nan) begin
              cur_fit <= '0;
              state   <= S_STORE;
            end else if (loss == '0) begin
              cur_fit <= FIT_MAX;
              state   <= S_STORE;
            end else begin
              state <= S_DIVW;
            end
          end
        end
        S_DIVW: begin
          if (div_done) begin
            cur_fit <= FIT_W'(div_q[RECIP_W-1:0]);
            state   <= S_STORE;
          end
        end
        S_STORE: begin
          item_count    <= item_count + 1'b1;
          sum_fitness   <= sum_fitness + SF_W'(cur_fit);
          sum_nodes     <= sum_nodes + SN_W'(cur_nodes);
          sum_fit_nodes <= sum_fit_nodes + SFN_W'(cur_fit * cur_nodes);
          sum_nodes_sq  <= sum_nodes_sq + SNN_W'(cur_nodes * cur_nodes);
          state         <= cur_last ? S_CT1 : S_IDLE;
        end
        S_CT1: begin
          term_a <= DIV_W'(item_count * sum_fit_nodes);
          term_b <= DIV_W'(sum_fitness * sum_nodes);
          term_c <= DSR_W'(item_count * sum_nodes_sq);
          term_d <= DSR_W'(sum_nodes * sum_nodes);
          state  <= S_CT2;
        end
        S_CT2: begin
          ct_neg <= mag_neg;
          k      <= '0;
          if (enable_reg && den != '0) begin
            state <= S_CTW;
          end else begin
            ct    <= '0;
            state <= S_RD;
          end
        end
        S_CTW: begin
          if (div_done) begin
            ct    <= (div_q > DIV_W'(CT_CLAMP)) ? CT_CLAMP : div_q[CT_W-1:0];
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          emit_fit  <= mem_rdata[MEM_W-1:NODE_W];
          emit_prod <= ct * mem_rdata[NODE_W-1:0];
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            fitness  <= sat_fit;
            slot     <= k[SLOT_W-1:0];
            last_out <= (k + 1'b1 == item_count);
            k        <= k + 1'b1;
            if (k + 1'b1 == item_count) begin
              // close the population
              item_count    <= '0;
              sum_fitness   <= '0;
              sum_nodes     <= '0;
              sum_fit_nodes <= '0;
              sum_nodes_sq  <= '0;
              state         <= S_IDLE;
            end else begin
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PFS_NEVER(a_div_overlap, div_req.start && div_busy)
  `PFS_NEVER(a_store_while_full, mem_we && (item_count >= CNT_W'(POP)))
  `PFS_ASSERT(a_slot_in_range, out_load |-> (k < item_count))
  `PFS_NEVER(a_accept_while_busy, in_acc && div_busy)
endmodule

// File: hdl/pfs_div.sv
// Shared restoring divider, one quotient bit per cycle, MSB first.
// Depends on pfs_pkg.
module pfs_div import pfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  pfs_div_req_t      req,
  output logic              busy,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);
  logic [DIV_W-1:0]  dvd;
  logic [DSR_W-1:0]  dsr;
  logic [DSR_W-1:0]  rem;
  logic [ITER_W-1:0] cnt;
  logic [DSR_W:0]    trial;
  logic              fits;

  assign trial = {rem, dvd[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        dvd      <= req.dividend;
        dsr      <= req.divisor;
        cnt      <= req.iters;
        rem      <= '0;
        quotient <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= DSR_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[DSR_W-1:0];
        end
        quotient <= {quotient[DIV_W-2:0], fits};
        dvd      <= {dvd[DIV_W-2:0], 1'b0};
        cnt      <= cnt - 1'b1;
        if (cnt == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hdl/pfs_store.sv
// Population store: fitness and node count per slot, one write and one
// registered read port. Depends on pfs_pkg.
module pfs_store import pfs_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  logic [MEM_W-1:0]  wdata,
  input  logic              re,
  input  logic [SLOT_W-1:0] raddr,
  output logic [MEM_W-1:0]  rdata
);
  logic [MEM_W-1:0] mem [POP];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
